>>> design/lrd_pkg.sv
// Shared types, constants and functions of the log record deframer.
package lrd_pkg;

    localparam int BLOCK_BYTES = 32768;
    localparam int BP_W = $clog2(BLOCK_BYTES);
    localparam logic [2:0] HDR_LEN = 3'd7;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PAYLOAD = 3'd1;
    localparam logic [2:0] PH_SKIP    = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;

    localparam logic [2:0] RS_NONE      = 3'd0;
    localparam logic [2:0] RS_PARTIAL   = 3'd1;
    localparam logic [2:0] RS_MISSING   = 3'd2;
    localparam logic [2:0] RS_MID       = 3'd3;
    localparam logic [2:0] RS_UNKNOWN   = 3'd4;
    localparam logic [2:0] RS_BADLEN    = 3'd5;
    localparam logic [2:0] RS_CHECKSUM  = 3'd6;
    localparam logic [2:0] RS_TRUNCATED = 3'd7;

    localparam logic [7:0] TY_ZERO   = 8'd0;
    localparam logic [7:0] TY_FULL   = 8'd1;
    localparam logic [7:0] TY_FIRST  = 8'd2;
    localparam logic [7:0] TY_MIDDLE = 8'd3;
    localparam logic [7:0] TY_LAST   = 8'd4;

    localparam logic CFG_INITIAL_OFFSET = 1'b0;
    localparam logic CFG_CHECKSUM       = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // One result item.
    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  payload_byte;
        logic        keep_fragment;
        logic        drop_pending;
        logic        deliver_record;
        logic [2:0]  reason;
        logic [31:0] dropped_bytes;
        logic        at_end;
    } result_t;

    // Up to two results caused by one input transaction.
    typedef struct packed {
        logic    first_valid;
        result_t first;
        logic    second_valid;
        result_t second;
    } result_pair_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 32'h82F6_3B78) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] unmask_crc(input logic [31:0] m);
        logic [31:0] r;
        r = m - 32'hA282_EAD8;
        return {r[16:0], r[31:17]};
    endfunction

    function automatic result_t verdict(input logic keep, input logic dropp,
                                        input logic deliver, input logic [2:0] rsn,
                                        input logic [31:0] dropped, input logic fin);
        result_t v;
        v.is_verdict = 1'b1;
        v.payload_byte = 8'd0;
        v.keep_fragment = keep;
        v.drop_pending = dropp;
        v.deliver_record = deliver;
        v.reason = rsn;
        v.dropped_bytes = dropped;
        v.at_end = fin;
        return v;
    endfunction

endpackage

>>> design/lrd_front.sv
// Front part: tracks positions, parses headers and decides each fragment's verdict.
module lrd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_file,
    input  logic                 cfg_valid,
    input  logic                 cfg_index,
    input  logic [47:0]          cfg_data,
    input  logic                 space_ok,
    output logic                 push,
    output lrd_pkg::result_pair_t push_data
);
    import lrd_pkg::*;

    logic [BP_W-1:0] block_position_reg, block_position_next;
    logic [47:0] file_position_reg, file_position_next;
    logic [2:0]  parse_phase_reg, parse_phase_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [31:0] stored_crc_reg, stored_crc_next;
    logic [15:0] fragment_length_reg, fragment_length_next;
    logic [7:0]  fragment_type_reg, fragment_type_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic        in_fragmented_reg, in_fragmented_next;
    logic        resync_active_reg, resync_active_next;
    logic [31:0] pending_bytes_reg, pending_bytes_next;
    logic [2:0]  skip_reason_reg, skip_reason_next;
    logic [31:0] skip_count_reg, skip_count_next;
    logic [47:0] initial_offset_reg;
    logic        checksum_enable_reg;
    // One bit wider than a file position: the search may start beyond the last position.
    logic [48:0] skip_target_reg;
    // Precomputed header-start compare is awkward; record start is computed per fragment.
    logic [47:0] frag_start_reg, frag_start_next;

    logic accept;
    assign in_ready = space_ok;
    assign accept = in_valid && in_ready;

    // Skip target: block start of the offset, or the next block if in its last 5 bytes.
    logic [48:0] skip_target_calc;
    always_comb
    begin
        skip_target_calc = {1'b0, cfg_data[47:BP_W], {BP_W{1'b0}}};
        if ({{(48-BP_W){1'b0}}, cfg_data[BP_W-1:0]} > 48'(BLOCK_BYTES - 6)) begin
            skip_target_calc = skip_target_calc + 49'(BLOCK_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            initial_offset_reg <= '0;
            checksum_enable_reg <= 1'b1;
            skip_target_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_INITIAL_OFFSET) begin
                initial_offset_reg <= cfg_data;
                skip_target_reg <= skip_target_calc;
            end else begin
                checksum_enable_reg <= cfg_data[0];
            end
        end
    end

    always_comb
    begin
        logic [31:0] bad_drop;
        logic [2:0]  bad_rsn;
        logic        part;
        logic [31:0] crc_nb;
        logic        fin_frag;
        logic [16:0] room;
        logic [15:0] len;
        logic [7:0]  ty;
        logic        r_pending;
        logic [2:0]  eof_rsn;
        logic        do_judge;
        logic        do_bad;
        logic [2:0]  bad_phys;
        logic [31:0] bad_cnt;
        result_t     r;
        logic [BP_W:0] bp_inc;

        block_position_next = block_position_reg;
        file_position_next = file_position_reg;
        parse_phase_next = parse_phase_reg;
        header_count_next = header_count_reg;
        stored_crc_next = stored_crc_reg;
        fragment_length_next = fragment_length_reg;
        fragment_type_next = fragment_type_reg;
        bytes_left_next = bytes_left_reg;
        running_crc_next = running_crc_reg;
        in_fragmented_next = in_fragmented_reg;
        resync_active_next = resync_active_reg;
        pending_bytes_next = pending_bytes_reg;
        skip_reason_next = skip_reason_reg;
        skip_count_next = skip_count_reg;
        frag_start_next = frag_start_reg;
        push_data = '0;
        bad_drop = '0;
        bad_rsn = RS_NONE;
        part = 1'b0;
        crc_nb = '0;
        fin_frag = 1'b0;
        room = '0;
        len = fragment_length_reg;
        ty = fragment_type_reg;
        r_pending = 1'b0;
        eof_rsn = RS_NONE;
        do_judge = 1'b0;
        do_bad = 1'b0;
        bad_phys = RS_NONE;
        bad_cnt = '0;
        r = '0;
        bp_inc = '0;

        if (cfg_valid && cfg_index == CFG_INITIAL_OFFSET) begin
            resync_active_next = (cfg_data != 48'd0);
        end

        if (accept && parse_phase_reg != PH_DONE) begin
            if (end_of_file) begin
                if (parse_phase_reg == PH_SKIP) begin
                    if (skip_reason_reg == RS_CHECKSUM) begin
                        push_data.first_valid = 1'b1;
                        push_data.first = verdict(1'b0, in_fragmented_reg, 1'b0, RS_CHECKSUM,
                            in_fragmented_reg ? sat_add(skip_count_reg, pending_bytes_reg)
                                              : skip_count_reg, 1'b0);
                    end else begin
                        eof_rsn = RS_TRUNCATED;
                    end
                end else if (parse_phase_reg == PH_PAYLOAD || header_count_reg != 3'd0) begin
                    eof_rsn = RS_TRUNCATED;
                end
                r = verdict(1'b0, (parse_phase_reg == PH_SKIP && skip_reason_reg == RS_CHECKSUM)
                                  ? 1'b0 : in_fragmented_reg, 1'b0, eof_rsn, 32'd0, 1'b1);
                if (push_data.first_valid) begin
                    push_data.second_valid = 1'b1;
                    push_data.second = r;
                end else begin
                    push_data.first_valid = 1'b1;
                    push_data.first = r;
                end
                in_fragmented_next = 1'b0;
                pending_bytes_next = '0;
                resync_active_next = 1'b0;
                header_count_next = '0;
                parse_phase_next = PH_DONE;
            end else begin
                unique case (parse_phase_reg)
                    PH_HEADER:
                    begin
                        if (header_count_reg == 3'd0 &&
                            ({1'b0, file_position_reg} < skip_target_reg ||
                             (17'(BLOCK_BYTES) - 17'(block_position_reg)) < 17'(HDR_LEN))) begin
                            // Before the skip target or inside a block trailer.
                        end else begin
                            unique case (header_count_reg)
                                3'd0: stored_crc_next = {24'd0, data_byte};
                                3'd1: stored_crc_next[15:8] = data_byte;
                                3'd2: stored_crc_next[23:16] = data_byte;
                                3'd3: stored_crc_next[31:24] = data_byte;
                                3'd4: fragment_length_next = {8'd0, data_byte};
                                3'd5: fragment_length_next[15:8] = data_byte;
                                default: ;
                            endcase
                            if (header_count_reg == 3'd0) begin
                                frag_start_next = file_position_reg;
                            end
                            if (header_count_reg == 3'd6) begin
                                ty = data_byte;
                                fragment_type_next = data_byte;
                                crc_nb = crc_byte(32'hFFFF_FFFF, data_byte);
                                running_crc_next = crc_nb;
                                header_count_next = '0;
                                room = 17'(BLOCK_BYTES) - (17'(block_position_reg) - 17'd6);
                                if (17'(HDR_LEN) + {1'b0, fragment_length_reg} > room) begin
                                    parse_phase_next = PH_SKIP;
                                    skip_reason_next = RS_BADLEN;
                                    skip_count_next = 32'(HDR_LEN);
                                end else if (data_byte == TY_ZERO && fragment_length_reg == 16'd0) begin
                                    do_bad = 1'b1;
                                end else if (fragment_length_reg == 16'd0) begin
                                    do_judge = 1'b1;
                                end else begin
                                    parse_phase_next = PH_PAYLOAD;
                                    bytes_left_next = fragment_length_reg;
                                end
                            end else begin
                                header_count_next = header_count_reg + 3'd1;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        push_data.first_valid = 1'b1;
                        push_data.first = '0;
                        push_data.first.payload_byte = data_byte;
                        crc_nb = crc_byte(running_crc_reg, data_byte);
                        running_crc_next = crc_nb;
                        bytes_left_next = bytes_left_reg - 16'd1;
                        if (bytes_left_reg == 16'd1) begin
                            parse_phase_next = PH_HEADER;
                            do_judge = 1'b1;
                        end
                    end
                    default:
                    begin
                        skip_count_next = sat_add(skip_count_reg, 32'd1);
                    end
                endcase

                // Fragment judgement.
                if (do_judge) begin
                    if (checksum_enable_reg && (~crc_nb) != unmask_crc(stored_crc_reg)) begin
                        parse_phase_next = PH_SKIP;
                        skip_reason_next = RS_CHECKSUM;
                        skip_count_next = 32'(HDR_LEN) + {16'd0, len};
                    end else if (frag_start_next < initial_offset_reg) begin
                        do_bad = 1'b1;
                    end else if (resync_active_reg && (ty == TY_MIDDLE || ty == TY_LAST)) begin
                        if (ty == TY_LAST) begin
                            resync_active_next = 1'b0;
                        end
                        r = verdict(1'b0, 1'b0, 1'b0, RS_NONE, 32'd0, 1'b0);
                        r_pending = 1'b1;
                    end else begin
                        resync_active_next = 1'b0;
                        part = in_fragmented_reg && pending_bytes_reg != 32'd0;
                        r_pending = 1'b1;
                        priority case (1'b1)
                            ty == TY_FULL:
                            begin
                                r = verdict(1'b1, 1'b1, 1'b1, part ? RS_PARTIAL : RS_NONE,
                                            part ? pending_bytes_reg : 32'd0, 1'b0);
                                in_fragmented_next = 1'b0;
                                pending_bytes_next = '0;
                            end
                            ty == TY_FIRST:
                            begin
                                r = verdict(1'b1, 1'b1, 1'b0, part ? RS_PARTIAL : RS_NONE,
                                            part ? pending_bytes_reg : 32'd0, 1'b0);
                                in_fragmented_next = 1'b1;
                                pending_bytes_next = {16'd0, len};
                            end
                            ty == TY_MIDDLE || ty == TY_LAST:
                            begin
                                if (!in_fragmented_reg) begin
                                    r = verdict(1'b0, 1'b0, 1'b0, RS_MISSING, {16'd0, len}, 1'b0);
                                end else if (ty == TY_MIDDLE) begin
                                    r = verdict(1'b1, 1'b0, 1'b0, RS_NONE, 32'd0, 1'b0);
                                    pending_bytes_next = sat_add(pending_bytes_reg, {16'd0, len});
                                end else begin
                                    r = verdict(1'b1, 1'b0, 1'b1, RS_NONE, 32'd0, 1'b0);
                                    in_fragmented_next = 1'b0;
                                    pending_bytes_next = '0;
                                end
                            end
                            default:
                            begin
                                r = verdict(1'b0, in_fragmented_reg, 1'b0, RS_UNKNOWN,
                                    in_fragmented_reg ? sat_add({16'd0, len}, pending_bytes_reg)
                                                      : {16'd0, len}, 1'b0);
                                in_fragmented_next = 1'b0;
                                pending_bytes_next = '0;
                            end
                        endcase
                    end
                end

                // Position advance and block-end skip report.
                file_position_next = file_position_reg + 48'd1;
                bp_inc = {1'b0, block_position_reg} + 1'b1;
                fin_frag = (bp_inc >= (BP_W+1)'(BLOCK_BYTES));
                block_position_next = fin_frag ? '0 : bp_inc[BP_W-1:0];
                if (parse_phase_next == PH_SKIP && fin_frag) begin
                    parse_phase_next = PH_HEADER;
                    do_bad = 1'b1;
                    bad_phys = skip_reason_next;
                    bad_cnt = skip_count_next;
                end

                if (do_bad) begin
                    bad_rsn = (bad_phys != RS_NONE) ? bad_phys
                            : (in_fragmented_reg ? RS_MID : RS_NONE);
                    bad_drop = in_fragmented_reg ? sat_add(bad_cnt, pending_bytes_reg) : bad_cnt;
                    resync_active_next = 1'b0;
                    r = verdict(1'b0, in_fragmented_reg, 1'b0, bad_rsn, bad_drop, 1'b0);
                    r_pending = 1'b1;
                    in_fragmented_next = 1'b0;
                    pending_bytes_next = '0;
                end

                if (r_pending) begin
                    if (push_data.first_valid) begin
                        push_data.second_valid = 1'b1;
                        push_data.second = r;
                    end else begin
                        push_data.first_valid = 1'b1;
                        push_data.first = r;
                    end
                end
            end
        end
    end

    assign push = accept && (push_data.first_valid || push_data.second_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            block_position_reg <= '0;
            file_position_reg <= '0;
            parse_phase_reg <= PH_HEADER;
            header_count_reg <= '0;
            stored_crc_reg <= '0;
            fragment_length_reg <= '0;
            fragment_type_reg <= '0;
            bytes_left_reg <= '0;
            running_crc_reg <= 32'hFFFF_FFFF;
            in_fragmented_reg <= 1'b0;
            resync_active_reg <= 1'b0;
            pending_bytes_reg <= '0;
            skip_reason_reg <= RS_NONE;
            skip_count_reg <= '0;
            frag_start_reg <= '0;
        end else begin
            block_position_reg <= block_position_next;
            file_position_reg <= file_position_next;
            parse_phase_reg <= parse_phase_next;
            header_count_reg <= header_count_next;
            stored_crc_reg <= stored_crc_next;
            fragment_length_reg <= fragment_length_next;
            fragment_type_reg <= fragment_type_next;
            bytes_left_reg <= bytes_left_next;
            running_crc_reg <= running_crc_next;
            in_fragmented_reg <= in_fragmented_next;
            resync_active_reg <= resync_active_next;
            pending_bytes_reg <= pending_bytes_next;
            skip_reason_reg <= skip_reason_next;
            skip_count_reg <= skip_count_next;
            frag_start_reg <= frag_start_next;
        end
    end

endmodule

>>> design/lrd_back.sv
// Back part: queue of result pairs and serialisation onto the output channel.
module lrd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lrd_pkg::result_pair_t push_data,
    output logic                  space_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lrd_pkg::result_t      out_item
);
    import lrd_pkg::*;

    result_pair_t     queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              half_reg, half_next;
    logic              pop;
    result_pair_t      head;

    assign head = queue_mem[rd_ptr_reg];
    assign space_ok = (count_reg < (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);

    always_comb
    begin
        if (!half_reg && head.first_valid) begin
            out_item = head.first;
        end else begin
            out_item = head.second;
        end
        pop = 1'b0;
        half_next = half_reg;
        if (out_valid && out_ready) begin
            if (!half_reg && head.first_valid && head.second_valid) begin
                half_next = 1'b1;
            end else begin
                half_next = 1'b0;
                pop = 1'b1;
            end
        end
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            half_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
            half_reg <= half_next;
        end
    end

endmodule

>>> design/log_record_deframer_unit.sv
// Top level of the log record deframer.
// The deframer reads a log file one byte per input transaction in blocks of 32768 bytes,
// skipping block trailers, parsing 7-byte headers and passing payload bytes straight
// through. After each fragment it produces a verdict transaction telling a downstream
// buffer whether to keep the fragment, discard pending fragments or deliver a record.
// One input transaction is accepted per clock cycle; each causes zero, one or two result
// transactions. The front part updates the per-byte CRC32C and header counters for each
// accepted byte, and a four-entry queue of result pairs sits between it and the output, so input
// is only held back when that queue is full, which happens when the output stalls or when
// several two-result transactions arrive together (each pair leaves as two output transactions).
// Configuration writes are always accepted; they should be made while the block is idle.
// After the end-of-file transaction no further results appear until reset.
module log_record_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_verdict,
    output logic [7:0]  payload_byte,
    output logic        keep_fragment,
    output logic        drop_pending,
    output logic        deliver_record,
    output logic [2:0]  reason,
    output logic [31:0] dropped_bytes,
    output logic        at_end
);
    import lrd_pkg::*;

    logic         space_ok;
    logic         push;
    result_pair_t push_data;
    result_t      out_item;

    assign cfg_ready = 1'b1;

    lrd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .end_of_file(end_of_file),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .space_ok   (space_ok),
        .push       (push),
        .push_data  (push_data)
    );

    lrd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .space_ok (space_ok),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    assign is_verdict = out_item.is_verdict;
    assign payload_byte = out_item.payload_byte;
    assign keep_fragment = out_item.keep_fragment;
    assign drop_pending = out_item.drop_pending;
    assign deliver_record = out_item.deliver_record;
    assign reason = out_item.reason;
    assign dropped_bytes = out_item.dropped_bytes;
    assign at_end = out_item.at_end;

endmodule

>>> test/log_record_deframer_unit_tb.sv
// Self-checking testbench of the log record deframer: byte stream stimulus against a scoreboard.
module log_record_deframer_unit_tb;
    import lrd_pkg::*;

    localparam int BLK = BLOCK_BYTES;
    localparam logic [31:0] CRC_DELTA = 32'hA282_EAD8;
    // Cycles that a result may still be on its way after the last expected one.
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {ST_HEADER, ST_PAYLOAD, ST_SKIP, ST_ENDED} parse_state_t;

    typedef struct packed {
        logic       eof;
        logic [7:0] b;
    } file_item_t;

    typedef struct packed {
        logic        idx;
        logic [47:0] val;
    } reg_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        end_of_file = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [47:0] cfg_data = 48'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        is_verdict;
    logic [7:0]  payload_byte;
    logic        keep_fragment;
    logic        drop_pending;
    logic        deliver_record;
    logic [2:0]  reason;
    logic [31:0] dropped_bytes;
    logic        at_end;

    log_record_deframer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .end_of_file(end_of_file),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .is_verdict(is_verdict), .payload_byte(payload_byte),
        .keep_fragment(keep_fragment), .drop_pending(drop_pending),
        .deliver_record(deliver_record), .reason(reason),
        .dropped_bytes(dropped_bytes), .at_end(at_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes waiting to be sent, register writes waiting, and results the deframer owes us.
    file_item_t byte_q[$];
    reg_write_t reg_q[$];
    result_t    owed_q[$];
    int         errors = 0;
    // While set, neither side of the stream idles.
    bit         no_gaps = 1'b0;

    // Shadow copy of the deframer's registers and parse state.
    logic [47:0]  sh_offset;
    logic         sh_check;
    int unsigned  sh_bpos;
    logic [47:0]  sh_fpos;
    parse_state_t sh_state;
    int unsigned  sh_hcnt;
    logic [31:0]  sh_hdr_crc;
    logic [15:0]  sh_len;
    logic [7:0]   sh_type;
    logic [15:0]  sh_left;
    logic [31:0]  sh_crc;
    logic         sh_frag;
    logic         sh_resync;
    logic [31:0]  sh_pending;
    logic [2:0]   sh_skip_rsn;
    logic [31:0]  sh_skip_cnt;

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] crc32c_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 32'h82F6_3B78) : (c >> 1);
        return c;
    endfunction

    function automatic logic [31:0] crc_unmasked(input logic [31:0] m);
        logic [31:0] r;
        r = m - CRC_DELTA;
        return {r[16:0], r[31:17]};
    endfunction

    function automatic logic [31:0] crc_masked(input logic [31:0] c);
        return {c[14:0], c[31:15]} + CRC_DELTA;
    endfunction

    // First file position at which headers are looked for.
    function automatic logic [48:0] header_search_start();
        logic [48:0] w;
        logic [48:0] t;
        w = {1'b0, sh_offset} % BLK;
        t = {1'b0, sh_offset} - w;
        if (w > BLK - 6)
            t = t + BLK;
        return t;
    endfunction

    task automatic owe_verdict(input logic keep, input logic dropp, input logic deliver,
                               input logic [2:0] rsn, input logic [31:0] cnt,
                               input logic fin);
        result_t r;
        r = '0;
        r.is_verdict = 1'b1;
        r.keep_fragment = keep;
        r.drop_pending = dropp;
        r.deliver_record = deliver;
        r.reason = rsn;
        r.dropped_bytes = cnt;
        r.at_end = fin;
        owed_q.push_back(r);
    endtask

    task automatic drop_fragment(input logic [2:0] phys_rsn, input logic [31:0] phys_cnt);
        logic [2:0]  rsn;
        logic [31:0] cnt;
        rsn = (phys_rsn != RS_NONE) ? phys_rsn : (sh_frag ? RS_MID : RS_NONE);
        cnt = sh_frag ? add_sat(phys_cnt, sh_pending) : phys_cnt;
        sh_resync = 1'b0;
        owe_verdict(1'b0, sh_frag, 1'b0, rsn, cnt, 1'b0);
        sh_frag = 1'b0;
        sh_pending = '0;
    endtask

    // A complete fragment of valid length has been read.
    task automatic judge_fragment();
        logic [47:0] start;
        logic        part;
        start = sh_fpos - 48'd6 - {32'd0, sh_len};
        if (sh_check && (~sh_crc) != crc_unmasked(sh_hdr_crc)) begin
            sh_state = ST_SKIP;
            sh_skip_rsn = RS_CHECKSUM;
            sh_skip_cnt = 32'd7 + sh_len;
            return;
        end
        if (start < sh_offset) begin
            drop_fragment(RS_NONE, '0);
            return;
        end
        if (sh_resync) begin
            if (sh_type == TY_MIDDLE || sh_type == TY_LAST) begin
                if (sh_type == TY_LAST)
                    sh_resync = 1'b0;
                owe_verdict(1'b0, 1'b0, 1'b0, RS_NONE, '0, 1'b0);
                return;
            end
            sh_resync = 1'b0;
        end
        part = sh_frag && sh_pending != 0;
        case (sh_type)
            TY_FULL:
            begin
                owe_verdict(1'b1, 1'b1, 1'b1, part ? RS_PARTIAL : RS_NONE,
                            part ? sh_pending : '0, 1'b0);
                sh_frag = 1'b0;
                sh_pending = '0;
            end
            TY_FIRST:
            begin
                owe_verdict(1'b1, 1'b1, 1'b0, part ? RS_PARTIAL : RS_NONE,
                            part ? sh_pending : '0, 1'b0);
                sh_frag = 1'b1;
                sh_pending = {16'd0, sh_len};
            end
            TY_MIDDLE, TY_LAST:
            begin
                if (!sh_frag)
                    owe_verdict(1'b0, 1'b0, 1'b0, RS_MISSING, {16'd0, sh_len}, 1'b0);
                else if (sh_type == TY_MIDDLE) begin
                    owe_verdict(1'b1, 1'b0, 1'b0, RS_NONE, '0, 1'b0);
                    sh_pending = add_sat(sh_pending, {16'd0, sh_len});
                end
                else begin
                    owe_verdict(1'b1, 1'b0, 1'b1, RS_NONE, '0, 1'b0);
                    sh_frag = 1'b0;
                    sh_pending = '0;
                end
            end
            default:
            begin
                owe_verdict(1'b0, sh_frag, 1'b0, RS_UNKNOWN,
                            sh_frag ? add_sat({16'd0, sh_len}, sh_pending)
                                    : {16'd0, sh_len}, 1'b0);
                sh_frag = 1'b0;
                sh_pending = '0;
            end
        endcase
    endtask

    task automatic take_header_byte(input logic [7:0] b);
        if (sh_hcnt < 4) begin
            if (sh_hcnt == 0)
                sh_hdr_crc = '0;
            sh_hdr_crc = sh_hdr_crc | ({24'd0, b} << (8 * sh_hcnt));
            sh_hcnt++;
        end
        else if (sh_hcnt == 4) begin
            sh_len = {8'd0, b};
            sh_hcnt++;
        end
        else if (sh_hcnt == 5) begin
            sh_len[15:8] = b;
            sh_hcnt++;
        end
        else begin
            sh_type = b;
            sh_crc = crc32c_step(32'hFFFF_FFFF, b);
            sh_hcnt = 0;
            if (7 + int'(sh_len) > BLK - (int'(sh_bpos) - 6)) begin
                sh_state = ST_SKIP;
                sh_skip_rsn = RS_BADLEN;
                sh_skip_cnt = 32'd7;
            end
            else if (sh_type == TY_ZERO && sh_len == 0)
                drop_fragment(RS_NONE, '0);
            else if (sh_len == 0)
                judge_fragment();
            else begin
                sh_state = ST_PAYLOAD;
                sh_left = sh_len;
            end
        end
    endtask

    // Works out the results of one accepted input transaction.
    task automatic predict_byte(input logic [7:0] b, input logic eof);
        logic [2:0] rsn;
        result_t    pr;
        if (sh_state == ST_ENDED)
            return;
        if (eof) begin
            rsn = RS_NONE;
            if (sh_state == ST_SKIP) begin
                if (sh_skip_rsn == RS_CHECKSUM)
                    drop_fragment(RS_CHECKSUM, sh_skip_cnt);
                else
                    rsn = RS_TRUNCATED;
            end
            else if (sh_state == ST_PAYLOAD || sh_hcnt != 0)
                rsn = RS_TRUNCATED;
            owe_verdict(1'b0, sh_frag, 1'b0, rsn, '0, 1'b1);
            sh_frag = 1'b0;
            sh_pending = '0;
            sh_resync = 1'b0;
            sh_hcnt = 0;
            sh_state = ST_ENDED;
            return;
        end
        case (sh_state)
            ST_HEADER:
            begin
                // Bytes before the search start, and block trailers, are thrown away.
                if (!(sh_hcnt == 0 && ({1'b0, sh_fpos} < header_search_start() ||
                                       BLK - int'(sh_bpos) < 7)))
                    take_header_byte(b);
            end
            ST_PAYLOAD:
            begin
                pr = '0;
                pr.payload_byte = b;
                owed_q.push_back(pr);
                sh_crc = crc32c_step(sh_crc, b);
                sh_left = sh_left - 16'd1;
                if (sh_left == 0) begin
                    sh_state = ST_HEADER;
                    judge_fragment();
                end
            end
            default:
                sh_skip_cnt = add_sat(sh_skip_cnt, 32'd1);
        endcase
        sh_fpos = sh_fpos + 48'd1;
        sh_bpos = (sh_bpos + 1 >= BLK) ? 0 : sh_bpos + 1;
        if (sh_state == ST_SKIP && sh_bpos == 0) begin
            sh_state = ST_HEADER;
            drop_fragment(sh_skip_rsn, sh_skip_cnt);
        end
    endtask

    task automatic apply_reg_write(input logic idx, input logic [47:0] val);
        if (idx == CFG_INITIAL_OFFSET) begin
            sh_offset = val;
            sh_resync = (val != 0);
        end
        else
            sh_check = val[0];
    endtask

    initial
    begin
        sh_offset = '0;
        sh_check = 1'b1;
        sh_bpos = 0;
        sh_fpos = '0;
        sh_state = ST_HEADER;
        sh_hcnt = 0;
        sh_hdr_crc = '0;
        sh_len = '0;
        sh_type = '0;
        sh_left = '0;
        sh_crc = 32'hFFFF_FFFF;
        sh_frag = 1'b0;
        sh_resync = 1'b0;
        sh_pending = '0;
        sh_skip_rsn = RS_NONE;
        sh_skip_cnt = '0;
    end

    // Byte driver: presents the next queued byte once the previous transaction is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready)
                predict_byte(data_byte, end_of_file);
            if (!in_valid || in_ready) begin
                if (byte_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 10)) begin
                    data_byte <= byte_q[0].b;
                    end_of_file <= byte_q[0].eof;
                    in_valid <= 1'b1;
                    void'(byte_q.pop_front());
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            if (!cfg_valid || cfg_ready) begin
                if (reg_q.size() > 0) begin
                    cfg_index <= reg_q[0].idx;
                    cfg_data <= reg_q[0].val;
                    cfg_valid <= 1'b1;
                    void'(reg_q.pop_front());
                end
                else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result monitor: every result transaction is checked against the oldest one owed.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: result with none expected, actual verdict %0b byte %0h",
                             $time, is_verdict, payload_byte);
                    errors++;
                end
                else begin
                    want = owed_q.pop_front();
                    report_field("is_verdict", 32'(want.is_verdict), 32'(is_verdict));
                    report_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
                    report_field("keep_fragment", 32'(want.keep_fragment),
                                 32'(keep_fragment));
                    report_field("drop_pending", 32'(want.drop_pending), 32'(drop_pending));
                    report_field("deliver_record", 32'(want.deliver_record),
                                 32'(deliver_record));
                    report_field("reason", 32'(want.reason), 32'(reason));
                    report_field("dropped_bytes", want.dropped_bytes, dropped_bytes);
                    report_field("at_end", 32'(want.at_end), 32'(at_end));
                end
            end
            out_ready <= no_gaps || $urandom_range(0, 99) >= 10;
        end
    end

    // Stimulus side: its own idea of where the file is and whether checksums count.
    longint gen_pos = 0;
    bit     gen_check = 1'b1;

    task automatic send_byte(input logic [7:0] b);
        byte_q.push_back('{eof: 1'b0, b: b});
        gen_pos++;
    endtask

    function automatic int block_room();
        return BLK - int'(gen_pos % BLK);
    endfunction

    task automatic pad_block();
        int n;
        n = block_room();
        if (n != BLK)
            repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Appends a physical record; bad checksum plus checking on skips the block rest unless keep_block.
    task automatic send_record(input logic [7:0] ty, input int len, input bit bad_crc,
                               input bit keep_block);
        logic [7:0]  body[$];
        logic [31:0] c;
        logic [31:0] m;
        if (block_room() < 7)
            pad_block();
        if (7 + len > block_room())
            len = block_room() - 7;
        c = crc32c_step(32'hFFFF_FFFF, ty);
        repeat (len) begin
            body.push_back(8'($urandom_range(0, 255)));
            c = crc32c_step(c, body[$]);
        end
        m = crc_masked(~c);
        if (bad_crc)
            m = m ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++)
            send_byte(m[8 * i +: 8]);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(ty);
        foreach (body[i])
            send_byte(body[i]);
        if (bad_crc && gen_check && !keep_block)
            pad_block();
    endtask

    // A header whose length runs past the block end, followed by a few bytes of the block.
    task automatic send_bad_length(input int len);
        if (block_room() < 7)
            pad_block();
        if (len <= block_room() - 7)
            len = block_room() - 6;
        repeat (4) send_byte(8'($urandom_range(0, 255)));
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(TY_FULL);
        repeat (5) send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
    endfunction

    // Mostly well-formed records and fragment chains, the rest noise and broken chains.
    // Corrupted checksums are only sent while checking is off, so the stream keeps parsing.
    task automatic send_random_records(input int budget);
        longint stop_at;
        int     r;
        bit     bad;
        stop_at = gen_pos + budget;
        while (gen_pos < stop_at) begin
            r = $urandom_range(0, 99);
            bad = !gen_check && ($urandom_range(0, 99) < 3);
            if (r < 45)
                send_record(TY_FULL, pick_len(), bad, 1'b0);
            else if (r < 80) begin
                send_record(TY_FIRST, pick_len(), 1'b0, 1'b0);
                repeat ($urandom_range(0, 3))
                    send_record(TY_MIDDLE, pick_len(), 1'b0, 1'b0);
                send_record(TY_LAST, pick_len(), bad, 1'b0);
            end
            else if (r < 87) begin
                send_record(TY_FIRST, pick_len(), 1'b0, 1'b0);
                if ($urandom_range(0, 1))
                    send_record(TY_MIDDLE, pick_len(), 1'b0, 1'b0);
            end
            else if (r < 93)
                send_record($urandom_range(0, 1) ? TY_MIDDLE : TY_LAST, pick_len(), bad, 1'b0);
            else if (r < 96)
                send_record(TY_ZERO, 0, 1'b0, 1'b0);
            else
                send_record(8'($urandom_range(0, 255)), $urandom_range(0, 8), bad, 1'b0);
        end
    endtask

    // Waits until every byte is taken and every owed result has come, plus the drain time.
    task automatic wait_quiet();
        wait (byte_q.size() == 0 && !in_valid && owed_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        wait (owed_q.size() == 0);
    endtask

    task automatic write_reg(input logic idx, input logic [47:0] val);
        wait_quiet();
        reg_q.push_back('{idx: idx, val: val});
        if (idx == CFG_CHECKSUM)
            gen_check = val[0];
        wait (reg_q.size() == 0 && !cfg_valid);
        @(posedge clk);
    endtask

    initial
    begin
        int ending;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: offset zero, checksums on.
        write_reg(CFG_CHECKSUM, 48'd1);
        write_reg(CFG_INITIAL_OFFSET, 48'd0);
        send_record(TY_FULL, 0, 1'b0, 1'b0);
        send_record(TY_FULL, 3, 1'b0, 1'b0);
        send_record(TY_FIRST, 4, 1'b0, 1'b0);
        send_record(TY_MIDDLE, 2, 1'b0, 1'b0);
        send_record(TY_LAST, 5, 1'b0, 1'b0);
        // A new start while a record is open reports the partial record.
        send_record(TY_FIRST, 3, 1'b0, 1'b0);
        send_record(TY_FULL, 2, 1'b0, 1'b0);
        // A zero record inside an open record is an error in the middle of it.
        send_record(TY_FIRST, 1, 1'b0, 1'b0);
        send_record(TY_ZERO, 0, 1'b0, 1'b0);
        send_record(TY_ZERO, 0, 1'b0, 1'b0);
        send_record(TY_MIDDLE, 4, 1'b0, 1'b0);
        send_record(TY_LAST, 0, 1'b0, 1'b0);
        send_record(8'd5, 3, 1'b0, 1'b0);
        send_record(TY_FIRST, 2, 1'b0, 1'b0);
        send_record(8'hFF, 6, 1'b0, 1'b0);
        send_record(TY_ZERO, 3, 1'b0, 1'b0);

        // Random records with checksums on, with the stream running without gaps.
        wait_quiet();
        no_gaps = 1'b1;
        send_random_records(160);
        wait_quiet();
        no_gaps = 1'b0;

        // Checksums off: corrupted records now pass.
        write_reg(CFG_CHECKSUM, 48'd0);
        send_record(TY_FULL, 5, 1'b1, 1'b0);
        send_random_records(100);

        // A nonzero offset a little ahead: early records drop and resync starts.
        write_reg(CFG_INITIAL_OFFSET, 48'(gen_pos + $urandom_range(1, 20)));
        send_record(TY_MIDDLE, 3, 1'b0, 1'b0);
        send_record(TY_MIDDLE, 2, 1'b0, 1'b0);
        send_record(TY_LAST, 4, 1'b0, 1'b0);
        send_random_records(100);
        write_reg(CFG_INITIAL_OFFSET, 48'(gen_pos + 3));
        send_record(TY_MIDDLE, 4, 1'b0, 1'b0);
        send_record(TY_FULL, 2, 1'b0, 1'b0);
        send_record(TY_FULL, 2, 1'b0, 1'b0);

        // An offset in the last bytes of its block moves the search to the next block,
        // so everything up to that block is passed over.
        write_reg(CFG_INITIAL_OFFSET, 48'(gen_pos - (gen_pos % BLK) + BLK - 3));
        send_record(TY_FULL, 4, 1'b0, 1'b0);
        send_random_records(20);

        // The largest offset: nothing is ever searched.
        write_reg(CFG_INITIAL_OFFSET, 48'hFFFF_FFFF_FFFF);
        send_random_records(30);

        // Back to offset zero and checksums on for the last random stretch.
        write_reg(CFG_INITIAL_OFFSET, 48'd0);
        write_reg(CFG_CHECKSUM, 48'd1);
        send_random_records(120);

        // End of file, in a randomly chosen position of the parse.
        if ($urandom_range(0, 1))
            send_record(TY_FIRST, 3, 1'b0, 1'b0);
        ending = $urandom_range(0, 4);
        if (ending == 1)
            repeat (3) send_byte(8'($urandom_range(0, 255)));
        else if (ending == 2) begin
            send_byte(8'h00);
            send_byte(8'h00);
            send_byte(8'h00);
            send_byte(8'h00);
            send_byte(8'd10);
            send_byte(8'd0);
            send_byte(TY_FULL);
            repeat (4) send_byte(8'($urandom_range(0, 255)));
        end
        else if (ending == 3)
            send_record(TY_FULL, 5, 1'b1, 1'b1);
        else if (ending == 4)
            send_bad_length(65535);
        byte_q.push_back('{eof: 1'b1, b: 8'($urandom_range(0, 255))});
        // Bytes after the end of file give nothing.
        send_byte(8'($urandom_range(0, 255)));

        wait_quiet();
        if (errors == 0 && owed_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
